// ===== src/assert_macros.svh =====
// Assertion macros shared by the loader RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off during reset
`define HRFL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication
`define HRFL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/hrfl_pkg.sv =====
// Shared types and constants of the HEX record flash loader.
// No dependencies; the parser, queue, writer and top files refer to it by scoped names.
package hrfl_pkg;

    // Key register value after reset
    localparam logic [31:0] KEY_RESET = 32'h1234_5600;

    // Status codes of a result
    localparam logic [1:0] ST_UPLOAD = 2'd0;
    localparam logic [1:0] ST_OK     = 2'd1;
    localparam logic [1:0] ST_CSUM   = 2'd2;
    localparam logic [1:0] ST_KEY    = 2'd3;

    // Record type byte values
    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF  = 8'h01;
    localparam logic [7:0] TYPE_EXT  = 8'h04;
    localparam logic [7:0] TYPE_KEY  = 8'h06;

    // Record kind held while a record is parsed
    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_EXT     = 3'd4;
    localparam logic [2:0] KIND_KEY     = 3'd6;
    localparam logic [2:0] KIND_UNKNOWN = 3'd7;

    // Command from parser to writer
    typedef enum logic {
        CMD_STATUS = 1'b0,
        CMD_FLUSH  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  status;
        logic [5:0]  words;
        logic [31:0] base;
    } cmd_t;

    // Data byte write into the record buffer
    typedef struct packed {
        logic       en;
        logic [7:0] pos;
        logic [7:0] data;
    } mem_wr_t;

    // Writer status back to the parser
    typedef struct packed {
        logic flush_done;
    } back_stat_t;

endpackage

// ===== src/hrfl_channels.sv =====
// Valid/ready channel interfaces of the loader: byte input, key write, results.
// Depends on nothing.
interface hrfl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hrfl_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_value;

    modport source (output valid, output key_value, input ready);
    modport sink   (input valid, input key_value, output ready);
endinterface

interface hrfl_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        write_valid;
    logic [31:0] write_address;
    logic [31:0] write_word;
    logic        last;

    modport source (output valid, output status, output write_valid,
                    output write_address, output write_word, output last,
                    input ready);
    modport sink   (input valid, input status, input write_valid,
                    input write_address, input write_word, input last,
                    output ready);
endinterface

// ===== src/hrfl_front.sv =====
// Record parser: takes bytes, tracks record fields and checksum, issues commands.
// Depends on hrfl_pkg, hrfl_channels and assert_macros.svh.
`include "assert_macros.svh"

module hrfl_front #(
    parameter int RECORD_BYTES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    hrfl_byte_if.sink           rx,
    hrfl_cfg_if.sink            cfg,
    output hrfl_pkg::cmd_t      cmd,
    output logic                cmd_push,
    input  logic                q_full,
    input  hrfl_pkg::back_stat_t bstat,
    output hrfl_pkg::mem_wr_t   mem_wr
);

    localparam logic [8:0] DEPTH_LIM = 9'(RECORD_BYTES);

    typedef enum logic [5:0] {
        PH_COUNT = 6'b000001,
        PH_ADDR  = 6'b000010,
        PH_TYPE  = 6'b000100,
        PH_DATA  = 6'b001000,
        PH_SUM   = 6'b010000,
        PH_END   = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  skip_reg, skip_next;
    logic [8:0]  idx_reg, idx_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] offset_reg, offset_next;
    logic [2:0]  kind_reg, kind_next;
    logic [15:0] upper_reg, upper_next;
    logic [31:0] key_acc_reg, key_acc_next;
    logic        key_ok_reg, key_ok_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] key_value_reg, key_value_next;
    logic        pending_reg, pending_next;

    logic        accept;
    logic [7:0]  b;
    logic [8:0]  pos;
    logic [9:0]  pos_plus;
    logic [7:0]  sum_add;

    // Hold off all bytes while the command queue is full, and data bytes while the buffer still drains to flash
    assign rx.ready  = !q_full && !(phase_reg == PH_DATA && pending_reg);
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid && rx.ready;
    assign cmd_push  = accept;
    assign b         = rx.rx_byte;
    assign pos       = idx_reg - 9'd4;
    assign pos_plus  = {1'b0, pos} + 10'd1;
    assign sum_add   = sum_reg + b;

    // Parser next state
    always_comb
    begin
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        offset_next    = offset_reg;
        kind_next      = kind_reg;
        upper_next     = upper_reg;
        key_acc_next   = key_acc_reg;
        key_ok_next    = key_ok_reg;
        sum_next       = sum_reg;
        key_value_next = key_value_reg;
        pending_next   = pending_reg;
        cmd.kind       = hrfl_pkg::CMD_STATUS;
        cmd.status     = hrfl_pkg::ST_UPLOAD;
        cmd.words      = 6'd0;
        cmd.base       = 32'd0;
        mem_wr.en      = 1'b0;
        mem_wr.pos     = pos[7:0];
        mem_wr.data    = b;

        if (bstat.flush_done)
        begin
            pending_next = 1'b0;
        end

        if (cfg.valid)
        begin
            key_value_next = cfg.key_value;
        end

        if (accept)
        begin
            priority if (skip_reg != 2'd0)
            begin
                // filler byte
                skip_next = skip_reg - 2'd1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_COUNT:
                    begin
                        count_next  = b;
                        sum_next    = b;
                        offset_next = 16'd0;
                        idx_next    = 9'd1;
                        phase_next  = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        offset_next = {offset_reg[7:0], b};
                        sum_next    = sum_add;
                        idx_next    = idx_reg + 9'd1;
                        if (idx_reg + 9'd1 >= 9'd3)
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        sum_next = sum_add;
                        idx_next = idx_reg + 9'd1;
                        if (b == hrfl_pkg::TYPE_EOF)
                        begin
                            cmd.status = hrfl_pkg::ST_OK;
                            phase_next = PH_END;
                        end
                        else
                        begin
                            if (b == hrfl_pkg::TYPE_DATA || b == hrfl_pkg::TYPE_EXT ||
                                b == hrfl_pkg::TYPE_KEY)
                            begin
                                kind_next = b[2:0];
                            end
                            else
                            begin
                                kind_next = hrfl_pkg::KIND_UNKNOWN;
                            end
                            if (b == hrfl_pkg::TYPE_EXT)
                            begin
                                upper_next = 16'd0;
                            end
                            if (b == hrfl_pkg::TYPE_KEY)
                            begin
                                key_acc_next = 32'd0;
                            end
                            // empty record goes straight to its checksum
                            phase_next = (count_reg == 8'd0) ? PH_SUM : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        mem_wr.en = ({1'b0, pos} < {1'b0, DEPTH_LIM}) ? 1'b1 : 1'b0;
                        sum_next  = sum_add;
                        if (kind_reg == hrfl_pkg::KIND_EXT)
                        begin
                            upper_next = {upper_reg[7:0], b};
                        end
                        if (kind_reg == hrfl_pkg::KIND_KEY)
                        begin
                            key_acc_next = (key_acc_reg + {24'd0, b}) << 8;
                        end
                        idx_next = idx_reg + 9'd1;
                        if (pos_plus >= {2'b00, count_reg})
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        priority if (sum_add != 8'd0)
                        begin
                            cmd.status = hrfl_pkg::ST_CSUM;
                        end
                        else if (kind_reg == hrfl_pkg::KIND_KEY)
                        begin
                            if (key_acc_reg == key_value_reg)
                            begin
                                key_ok_next = 1'b1;
                                cmd.status  = hrfl_pkg::ST_OK;
                            end
                            else
                            begin
                                cmd.status = hrfl_pkg::ST_KEY;
                            end
                        end
                        else if (kind_reg == hrfl_pkg::KIND_DATA && key_ok_reg)
                        begin
                            cmd.status = hrfl_pkg::ST_OK;
                            // only whole words are written
                            if (count_reg[7:2] != 6'd0)
                            begin
                                cmd.kind     = hrfl_pkg::CMD_FLUSH;
                                cmd.words    = count_reg[7:2];
                                cmd.base     = {upper_reg, offset_reg};
                                pending_next = 1'b1;
                            end
                        end
                        else if (kind_reg == hrfl_pkg::KIND_EXT)
                        begin
                            cmd.status = hrfl_pkg::ST_OK;
                        end
                        else
                        begin
                            cmd.status = hrfl_pkg::ST_UPLOAD;
                        end
                        phase_next  = PH_COUNT;
                        idx_next    = 9'd0;
                        count_next  = 8'd0;
                        offset_next = 16'd0;
                        kind_next   = hrfl_pkg::KIND_UNKNOWN;
                        sum_next    = 8'd0;
                        skip_next   = 2'd1;
                    end
                    default:
                    begin
                        // byte after end of file: full restart
                        cmd.status   = hrfl_pkg::ST_OK;
                        phase_next   = PH_COUNT;
                        idx_next     = 9'd0;
                        count_next   = 8'd0;
                        offset_next  = 16'd0;
                        kind_next    = hrfl_pkg::KIND_UNKNOWN;
                        sum_next     = 8'd0;
                        upper_next   = 16'd0;
                        key_acc_next = 32'd0;
                        key_ok_next  = 1'b0;
                        skip_next    = 2'd2;
                    end
                endcase
            end
        end
    end

    // Parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_COUNT;
            skip_reg      <= 2'd2;
            idx_reg       <= 9'd0;
            count_reg     <= 8'd0;
            offset_reg    <= 16'd0;
            kind_reg      <= hrfl_pkg::KIND_UNKNOWN;
            upper_reg     <= 16'd0;
            key_acc_reg   <= 32'd0;
            key_ok_reg    <= 1'b0;
            sum_reg       <= 8'd0;
            key_value_reg <= hrfl_pkg::KEY_RESET;
            pending_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            offset_reg    <= offset_next;
            kind_reg      <= kind_next;
            upper_reg     <= upper_next;
            key_acc_reg   <= key_acc_next;
            key_ok_reg    <= key_ok_next;
            sum_reg       <= sum_next;
            key_value_reg <= key_value_next;
            pending_reg   <= pending_next;
        end
    end

    // Buffer is never overwritten while the writer reads it
    `HRFL_ASSERT_IMPL(a_no_write_in_flush, mem_wr.en, !pending_reg, "data write during flush")
    `HRFL_ASSERT(a_flush_marks_pending, cmd_push && cmd.kind == hrfl_pkg::CMD_FLUSH |=> pending_reg, "flush not marked pending")

endmodule

// ===== src/hrfl_cmd_queue.sv =====
// Two-entry command queue between the parser and the flash word writer.
// Depends on hrfl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hrfl_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hrfl_pkg::cmd_t cmd_in,
    output logic           full,
    input  logic           pop,
    output hrfl_pkg::cmd_t head,
    output logic           head_valid
);

    hrfl_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    `HRFL_ASSERT_IMPL(a_no_overflow, push && !pop, count_reg < 2'd2, "command queue overflow")
    `HRFL_ASSERT_IMPL(a_no_underflow, pop, count_reg != 2'd0, "command queue underflow")

endmodule

// ===== src/hrfl_back.sv =====
// Flash word writer: runs commands, holds the record buffer, drives results.
// Depends on hrfl_pkg, hrfl_channels and assert_macros.svh.
`include "assert_macros.svh"

module hrfl_back #(
    parameter int RECORD_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hrfl_pkg::cmd_t       q_cmd,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  hrfl_pkg::mem_wr_t    mem_wr,
    output hrfl_pkg::back_stat_t bstat,
    hrfl_result_if.source        result
);

    localparam int         AW        = $clog2(RECORD_BYTES);
    localparam logic [8:0] DEPTH_LIM = 9'(RECORD_BYTES);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_EMIT = 3'b100
    } bstate_t;

    logic [7:0]  mem [RECORD_BYTES];

    bstate_t     state_reg, state_next;
    logic [5:0]  words_reg, words_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  pos_reg, pos_next;
    logic [2:0]  issue_cnt_reg, issue_cnt_next;
    logic [31:0] word_reg, word_next;
    logic        rd_vld_reg;
    logic [1:0]  rd_lane_reg;
    logic        rd_oor_reg;
    logic [7:0]  mem_q_reg;
    logic        issue;
    logic        pos_oor;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic        out_wv_reg, out_wv_next;
    logic [31:0] out_addr_reg, out_addr_next;
    logic [31:0] out_word_reg, out_word_next;
    logic        out_last_reg, out_last_next;
    logic        out_free;

    assign out_free = !out_valid_reg || result.ready;
    assign pos_oor  = ({1'b0, pos_reg} >= DEPTH_LIM);

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.write_valid   = out_wv_reg;
    assign result.write_address = out_addr_reg;
    assign result.write_word    = out_word_reg;
    assign result.last          = out_last_reg;

    // Command sequencer
    always_comb
    begin
        state_next       = state_reg;
        words_next       = words_reg;
        addr_next        = addr_reg;
        pos_next         = pos_reg;
        issue_cnt_next   = issue_cnt_reg;
        issue            = 1'b0;
        q_pop            = 1'b0;
        bstat.flush_done = 1'b0;
        out_valid_next   = out_valid_reg && !result.ready;
        out_status_next  = out_status_reg;
        out_wv_next      = out_wv_reg;
        out_addr_next    = out_addr_reg;
        out_word_next    = out_word_reg;
        out_last_next    = out_last_reg;

        // assemble word from the byte read last cycle
        word_next = word_reg;
        if (rd_vld_reg)
        begin
            word_next[{rd_lane_reg, 3'b000} +: 8] = rd_oor_reg ? 8'd0 : mem_q_reg;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.kind == hrfl_pkg::CMD_FLUSH)
                    begin
                        q_pop          = 1'b1;
                        words_next     = q_cmd.words;
                        addr_next      = q_cmd.base;
                        pos_next       = 8'd0;
                        issue_cnt_next = 3'd0;
                        state_next     = B_READ;
                    end
                    else if (out_free)
                    begin
                        q_pop           = 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = q_cmd.status;
                        out_wv_next     = 1'b0;
                        out_addr_next   = 32'd0;
                        out_word_next   = 32'd0;
                        out_last_next   = 1'b1;
                    end
                end
            end
            B_READ:
            begin
                // one buffer byte per cycle, four per word
                if (issue_cnt_reg != 3'd4)
                begin
                    issue          = 1'b1;
                    pos_next       = pos_reg + 8'd1;
                    issue_cnt_next = issue_cnt_reg + 3'd1;
                end
                if (rd_vld_reg && rd_lane_reg == 2'd3)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = hrfl_pkg::ST_OK;
                    out_wv_next     = 1'b1;
                    out_addr_next   = addr_reg;
                    out_word_next   = word_reg;
                    out_last_next   = (words_reg == 6'd1);
                    addr_next       = addr_reg + 32'd4;
                    words_next      = words_reg - 6'd1;
                    if (words_reg == 6'd1)
                    begin
                        bstat.flush_done = 1'b1;
                        state_next       = B_IDLE;
                    end
                    else
                    begin
                        issue_cnt_next = 3'd0;
                        state_next     = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            issue_cnt_reg <= 3'd0;
            words_reg     <= 6'd0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            words_reg     <= words_next;
            rd_vld_reg    <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        pos_reg        <= pos_next;
        word_reg       <= word_next;
        rd_lane_reg    <= issue_cnt_reg[1:0];
        rd_oor_reg     <= pos_oor;
        out_status_reg <= out_status_next;
        out_wv_reg     <= out_wv_next;
        out_addr_reg   <= out_addr_next;
        out_word_reg   <= out_word_next;
        out_last_reg   <= out_last_next;
    end

    // Record buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.pos[AW-1:0]] <= mem_wr.data;
        end
        if (issue && !pos_oor)
        begin
            mem_q_reg <= mem[pos_reg[AW-1:0]];
        end
    end

    `HRFL_ASSERT_IMPL(a_write_is_ok, result.valid && result.write_valid, result.status == hrfl_pkg::ST_OK, "word write without success status")
    `HRFL_ASSERT(a_done_on_last, bstat.flush_done |=> result.valid && result.write_valid && result.last, "flush done without last word")

endmodule

// ===== src/hex_record_flash_loader.sv =====
// HEX record flash loader: parser front, command queue, flash word writer back.
// Status results: a status command is queued when its byte is accepted, then registered onto
// the result channel once the writer is idle and its output is free. Words: after the checksum
// byte, each word takes four single-byte reads of the record buffer's read port plus the output load.
// Throughput: one byte per cycle while the command queue is not full; data bytes wait while a record's words drain.
// Reset: asynchronous active-low rst_n clears control state; no clearing pass.
module hex_record_flash_loader #(
    parameter int RECORD_BYTES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    hrfl_byte_if.sink     rx,
    hrfl_cfg_if.sink      cfg,
    hrfl_result_if.source result
);

    hrfl_pkg::cmd_t       push_cmd;
    hrfl_pkg::cmd_t       head_cmd;
    logic                 push;
    logic                 full;
    logic                 pop;
    logic                 head_valid;
    hrfl_pkg::mem_wr_t    mem_wr;
    hrfl_pkg::back_stat_t bstat;

    // Byte parser
    hrfl_front #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cfg      (cfg),
        .cmd      (push_cmd),
        .cmd_push (push),
        .q_full   (full),
        .bstat    (bstat),
        .mem_wr   (mem_wr)
    );

    // Decoupling queue
    hrfl_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .cmd_in     (push_cmd),
        .full       (full),
        .pop        (pop),
        .head       (head_cmd),
        .head_valid (head_valid)
    );

    // Flash word writer
    hrfl_back #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_cmd   (head_cmd),
        .q_valid (head_valid),
        .q_pop   (pop),
        .mem_wr  (mem_wr),
        .bstat   (bstat),
        .result  (result)
    );

endmodule
